// ===== hdl/lcbt_pkg.sv =====
// Shared types and constants for the lifetime cohort bound tracker.
// Holds the slot count, field widths, command and register codes, and the table control struct.
// No dependencies.
package lcbt_pkg;

    // Table geometry.
    localparam int SLOTS = 8;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Field widths.
    localparam int CNT_W   = 8;
    localparam int CMD_W   = 2;
    localparam int BURST_W = 10;
    localparam int SUM_W   = $clog2(SLOTS * 255 + 1);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BURST = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Configuration register indexes (register i at byte address 4*i).
    localparam logic REG_LIFETIME = 1'b0;
    localparam logic REG_CEILING  = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CNT_W-1:0] LIFETIME_RST = 8'd60;
    localparam logic [CNT_W-1:0] CEILING_RST  = 8'd64;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [IDX_W-1:0] idx_t;

    // Control from the sequencer to the cohort table.
    typedef struct packed {
        logic clear;
        logic wr_en;
        idx_t wr_idx;
        cnt_t wr_frames;
        cnt_t wr_count;
        idx_t rd_idx;
    } tbl_ctrl_t;

endpackage

// ===== hdl/lcbt_table.sv =====
// Cohort table: frames-left counters and item counts, one entry per slot.
// Depends on lcbt_pkg for the slot count, types and the control struct.
// One write port, one read port, and a clear that empties the whole table at once.
module lcbt_table (
    input  logic               clk,
    input  logic               rst_n,
    input  lcbt_pkg::tbl_ctrl_t ctrl,
    output lcbt_pkg::cnt_t     rd_frames,
    output lcbt_pkg::cnt_t     rd_count
);
    import lcbt_pkg::*;

    cnt_t frames_reg [SLOTS];
    cnt_t count_reg  [SLOTS];

    // Table storage; reset and the clear command empty every slot at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                frames_reg[i] <= '0;
                count_reg[i]  <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                frames_reg[i] <= '0;
                count_reg[i]  <= '0;
            end
        end
        else if (ctrl.wr_en)
        begin
            frames_reg[ctrl.wr_idx] <= ctrl.wr_frames;
            count_reg[ctrl.wr_idx]  <= ctrl.wr_count;
        end
    end

    // Read port used by the slot walk.
    assign rd_frames = frames_reg[ctrl.rd_idx];
    assign rd_count  = count_reg[ctrl.rd_idx];

endmodule

// ===== hdl/lifetime_cohort_bound_tracker.sv =====
// Top level of the cohort bound tracker; uses lcbt_pkg and the lcbt_table slot store.
// Sequence: an accepted command walks every slot through the shared slot update unit, then the
// finish state registers the result and out_valid; a burst merged into a slot also passes S_MERGE and S_ADDB.
// Flow: one command at a time; in_ready returns only once the result has been taken.
// Reset (rst_n, asynchronous): table cleared, lifetime 60, ceiling 64, no result pending.
module lifetime_cohort_bound_tracker (
    input  logic                         clk,
    input  logic                         rst_n,
    // Command channel.
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [lcbt_pkg::CMD_W-1:0]   command,
    input  logic [lcbt_pkg::BURST_W-1:0] burst_count,
    // Result channel.
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [lcbt_pkg::CNT_W-1:0]   live_bound,
    output logic                         folded,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import lcbt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_MERGE = 3'd2;
    localparam logic [2:0] S_ADDB  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CMD_W-1:0] cmd_reg;
    cnt_t             tracked_reg;
    idx_t             idx_reg;
    logic             placed_reg;
    idx_t             best_idx_reg;
    cnt_t             best_f_reg;
    cnt_t             best_cnt_reg;
    logic [SUM_W-1:0] raw_reg;
    logic             folded_reg;
    cnt_t             bound_reg;
    logic             out_valid_reg;
    cnt_t             lifetime_reg;
    cnt_t             ceiling_reg;

    tbl_ctrl_t        ctrl;
    cnt_t             rd_frames;
    cnt_t             rd_count;

    logic             accept;
    logic             cfg_wr;
    logic             last_slot;
    logic             take_free;
    logic             new_best;
    cnt_t             contrib;
    cnt_t             tracked_in;
    logic [CNT_W:0]   merge_sum;
    cnt_t             merge_cnt;
    cnt_t             merge_f;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;

    assign out_valid  = out_valid_reg;
    assign live_bound = bound_reg;
    assign folded     = folded_reg;

    // Register read-back.
    assign prdata = (paddr[2] == REG_CEILING) ? {24'd0, ceiling_reg} : {24'd0, lifetime_reg};

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lifetime_reg <= LIFETIME_RST;
            ceiling_reg  <= CEILING_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_LIFETIME)
            begin
                lifetime_reg <= pwdata[CNT_W-1:0];
            end
            else
            begin
                ceiling_reg <= pwdata[CNT_W-1:0];
            end
        end
    end

    // Burst size clamped to the ceiling when the transaction is accepted.
    assign tracked_in = (burst_count > {2'b00, ceiling_reg}) ? ceiling_reg
                                                             : burst_count[CNT_W-1:0];

    // Shared slot update unit: works on the slot under the walk index.
    assign last_slot = (idx_reg == idx_t'(SLOTS - 1));
    assign take_free = (cmd_reg == CMD_BURST) && !placed_reg && (rd_frames == '0);
    assign new_best  = (cmd_reg == CMD_BURST) && !placed_reg && (rd_frames > best_f_reg);

    // Merge into the longest-lived slot: saturated count, lifetime raised if longer.
    assign merge_sum = {1'b0, best_cnt_reg} + {1'b0, tracked_reg};
    assign merge_cnt = (merge_sum > {1'b0, ceiling_reg}) ? ceiling_reg : merge_sum[CNT_W-1:0];
    assign merge_f   = (lifetime_reg > best_f_reg) ? lifetime_reg : best_f_reg;

    always_comb
    begin
        ctrl           = '0;
        ctrl.rd_idx    = idx_reg;
        ctrl.clear     = accept && (command == CMD_CLEAR);
        ctrl.wr_idx    = idx_reg;
        ctrl.wr_frames = rd_frames;
        ctrl.wr_count  = rd_count;
        contrib        = (rd_frames != '0) ? rd_count : '0;

        if (state_reg == S_WALK)
        begin
            case (cmd_reg)
                CMD_TICK:
                begin
                    // Age a live slot; a slot that runs out drops its count.
                    ctrl.wr_en     = (rd_frames != '0);
                    ctrl.wr_frames = rd_frames - cnt_t'(1);
                    ctrl.wr_count  = (rd_frames == cnt_t'(1)) ? '0 : rd_count;
                    contrib        = (rd_frames > cnt_t'(1)) ? rd_count : '0;
                end
                CMD_BURST:
                begin
                    if (take_free)
                    begin
                        ctrl.wr_en     = 1'b1;
                        ctrl.wr_frames = lifetime_reg;
                        ctrl.wr_count  = tracked_reg;
                        contrib        = (lifetime_reg != '0) ? tracked_reg : '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == S_MERGE)
        begin
            ctrl.wr_en     = 1'b1;
            ctrl.wr_idx    = best_idx_reg;
            ctrl.wr_frames = merge_f;
            ctrl.wr_count  = merge_cnt;
        end
    end

    // Sequencer state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (last_slot)
                begin
                    if ((cmd_reg == CMD_BURST) && !placed_reg && !take_free)
                    begin
                        state_next = S_MERGE;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_MERGE:
            begin
                state_next = S_ADDB;
            end
            S_ADDB:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            placed_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_FIN)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (accept)
            begin
                idx_reg    <= '0;
                placed_reg <= 1'b0;
            end
            else if (state_reg == S_WALK)
            begin
                idx_reg <= idx_reg + idx_t'(1);
                if (take_free)
                begin
                    placed_reg <= 1'b1;
                end
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= command;
            tracked_reg  <= tracked_in;
            raw_reg      <= '0;
            best_idx_reg <= '0;
            best_f_reg   <= '0;
            best_cnt_reg <= '0;
            folded_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_WALK:
                begin
                    raw_reg <= raw_reg + SUM_W'(contrib);
                    if (new_best)
                    begin
                        best_idx_reg <= idx_reg;
                        best_f_reg   <= rd_frames;
                        best_cnt_reg <= rd_count;
                    end
                end
                S_MERGE:
                begin
                    // Take out the old count of the merged slot, then add the new one.
                    raw_reg      <= raw_reg - SUM_W'(best_cnt_reg);
                    best_cnt_reg <= merge_cnt;
                    folded_reg   <= 1'b1;
                end
                S_ADDB:
                begin
                    raw_reg <= raw_reg + SUM_W'(best_cnt_reg);
                end
                S_FIN:
                begin
                    bound_reg <= (raw_reg > SUM_W'(ceiling_reg)) ? ceiling_reg
                                                                 : raw_reg[CNT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    lcbt_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .rd_frames (rd_frames),
        .rd_count  (rd_count)
    );

endmodule

// ===== dv/tb_lifetime_cohort_bound_tracker.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for lifetime_cohort_bound_tracker: directed table, then random phases.
// Depends on lcbt_pkg (hdl/lcbt_pkg.sv) and the tracker RTL; needs nothing else.
module tb_lifetime_cohort_bound_tracker;
    import lcbt_pkg::*;

    localparam int ITEMS_PER_PHASE = 123;
    localparam int N_PHASES        = 10;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_TAIL      = 2 * SLOTS + 8;
    localparam int MAX_REPORTS     = 10;

    localparam logic [2:0] ADDR_LIFETIME = {REG_LIFETIME, 2'b00};
    localparam logic [2:0] ADDR_CEILING  = {REG_CEILING, 2'b00};

    typedef struct packed {
        cnt_t bound;
        logic fold;
    } cohort_report_t;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_SET_LIFETIME,
        ROW_SET_CEILING
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [CMD_W-1:0]   cmd;
        logic [BURST_W-1:0] value;
        logic               typed;
        cohort_report_t     want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [CMD_W-1:0]   command;
    logic [BURST_W-1:0] burst_count;
    logic               out_valid;
    logic               out_ready;
    cnt_t               live_bound;
    logic               folded;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Predicted cohort table and configuration.
    cnt_t slot_frames [SLOTS];
    cnt_t slot_count  [SLOTS];
    cnt_t cur_lifetime;
    cnt_t cur_ceiling;

    cohort_report_t expected_bounds [$];
    stim_row_t      directed_rows [$];

    int unsigned error_count;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned folds_seen;
    bit          quiet_phase;
    bit          hold_off_pending;

    lifetime_cohort_bound_tracker u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .burst_count (burst_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .live_bound  (live_bound),
        .folded      (folded),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Gap length for either side: mostly short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(0, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        else
            return $urandom_range(20, 60);
    endfunction

    // Applies one command to the predicted table and returns the bound it reports.
    task automatic cohort_step(input logic [CMD_W-1:0] cmd, input logic [BURST_W-1:0] amount,
                               output cohort_report_t rep);
        int unsigned tracked;
        int unsigned merged_sum;
        int unsigned total;
        int          best;
        bit          placed;
        rep.fold = 1'b0;
        if (cmd == CMD_TICK)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (slot_frames[i] != '0)
                begin
                    slot_frames[i] = slot_frames[i] - cnt_t'(1);
                    if (slot_frames[i] == '0)
                        slot_count[i] = '0;
                end
            end
        end
        else if (cmd == CMD_BURST)
        begin
            tracked = (amount > cur_ceiling) ? 32'(cur_ceiling) : 32'(amount);
            best    = 0;
            placed  = 1'b0;
            // First free slot takes the burst; otherwise track the longest-lived slot.
            for (int i = 0; i < SLOTS && !placed; i++)
            begin
                if (slot_frames[i] == '0)
                begin
                    slot_frames[i] = cur_lifetime;
                    slot_count[i]  = cnt_t'(tracked);
                    placed         = 1'b1;
                end
                else if (slot_frames[i] > slot_frames[best])
                begin
                    best = i;
                end
            end
            if (!placed)
            begin
                merged_sum       = slot_count[best] + tracked;
                slot_count[best] = (merged_sum > cur_ceiling) ? cur_ceiling
                                                              : cnt_t'(merged_sum);
                if (cur_lifetime > slot_frames[best])
                    slot_frames[best] = cur_lifetime;
                rep.fold = 1'b1;
            end
        end
        else if (cmd == CMD_CLEAR)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_frames[i] = '0;
                slot_count[i]  = '0;
            end
        end
        // Bound over live cohorts, saturated at the ceiling.
        total = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_frames[i] != '0)
                total += slot_count[i];
        end
        rep.bound = (total > cur_ceiling) ? cur_ceiling : cnt_t'(total);
    endtask

    task automatic add_row(input row_kind_t kind, input logic [CMD_W-1:0] cmd,
                           input logic [BURST_W-1:0] value, input bit typed,
                           input cnt_t bound, input logic fold);
        stim_row_t row;
        row.kind       = kind;
        row.cmd        = cmd;
        row.value      = value;
        row.typed      = typed;
        row.want.bound = bound;
        row.want.fold  = fold;
        directed_rows.push_back(row);
    endtask

    // Offers one command, holds it until accepted, then records its expected result.
    task automatic offer_command(input logic [CMD_W-1:0] cmd, input logic [BURST_W-1:0] amount,
                                 input bit typed, input cohort_report_t typed_rep);
        cohort_report_t rep;
        int unsigned    gap;
        in_valid    <= 1'b1;
        command     <= cmd;
        burst_count <= amount;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        cohort_step(cmd, amount, rep);
        expected_bounds.push_back(typed ? typed_rep : rep);
        items_sent++;
        gap = quiet_phase ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering and waits until every outstanding result has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_bounds.size() != 0)
            @(posedge clk);
    endtask

    // APB write: setup phase, access phase, then a return to idle.
    task automatic write_register(input logic [2:0] addr, input cnt_t val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == ADDR_LIFETIME)
            cur_lifetime = val;
        else
            cur_ceiling = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch on result %0d: %s expected %0d, got %0d",
                     $realtime, results_seen, what, want, got);
    endtask

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        cohort_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (folded === 1'b1)
                folds_seen++;
            if (expected_bounds.size() == 0)
            begin
                report_mismatch("result with no command outstanding, live_bound", '0,
                                32'(live_bound));
            end
            else
            begin
                want = expected_bounds.pop_front();
                if (live_bound !== want.bound)
                    report_mismatch("live_bound", 32'(want.bound), 32'(live_bound));
                if (folded !== want.fold)
                    report_mismatch("folded", 32'(want.fold), 32'(folded));
            end
        end
    end

    // Result side: random back-pressure, one long hold-off on request.
    initial
    begin : result_sink
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_off_pending)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_pending = 1'b0;
            end
            else if (quiet_phase || $urandom_range(0, 99) < 70)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge clk);
            end
        end
    end

    // Ends the run when no transaction has happened for too long.
    initial
    begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, expected_bounds.size());
        $display("tb_lifetime_cohort_bound_tracker: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t          row;
        logic [CMD_W-1:0]   cmd;
        logic [BURST_W-1:0] amount;
        cnt_t               life;
        cnt_t               ceil;
        int unsigned        r;

        in_valid    <= 1'b0;
        command     <= CMD_TICK;
        burst_count <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        rst_n       <= 1'b0;

        error_count      = 0;
        items_sent       = 0;
        results_seen     = 0;
        folds_seen       = 0;
        quiet_phase      = 1'b0;
        hold_off_pending = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_frames[i] = '0;
            slot_count[i]  = '0;
        end
        cur_lifetime = LIFETIME_RST;
        cur_ceiling  = CEILING_RST;

        // Directed table. Default lifetime 60, ceiling 64 at the top.
        // Empty table after reset; the burst field is ignored by tick and clear.
        add_row(ROW_ITEM, CMD_TICK, 10'h3FF, 1, 8'd0, 1'b0);
        // Oversized burst clamps to the ceiling.
        add_row(ROW_ITEM, CMD_BURST, 10'h3FF, 1, 8'd64, 1'b0);
        add_row(ROW_ITEM, CMD_CLEAR, 10'h3FF, 1, 8'd0, 1'b0);
        add_row(ROW_ITEM, CMD_BURST, 10'd0, 1, 8'd0, 1'b0);
        // Fill the remaining slots.
        for (int i = 1; i < SLOTS; i++)
            add_row(ROW_ITEM, CMD_BURST, 10'd9, 0, 8'd0, 1'b0);
        // Full table: merge into slot zero on the lifetime tie, bound saturates.
        add_row(ROW_ITEM, CMD_BURST, 10'd40, 1, 8'd64, 1'b1);
        add_row(ROW_ITEM, CMD_TICK, 10'd0, 0, 8'd0, 1'b0);
        // A lifetime of zero leaves the slot free and uncounted.
        add_row(ROW_SET_LIFETIME, CMD_TICK, 10'd0, 0, 8'd0, 1'b0);
        add_row(ROW_ITEM, CMD_CLEAR, 10'd0, 1, 8'd0, 1'b0);
        add_row(ROW_ITEM, CMD_BURST, 10'd100, 1, 8'd0, 1'b0);
        // Short lifetime with the widest ceiling: cohorts expire after two ticks.
        add_row(ROW_SET_LIFETIME, CMD_TICK, 10'd2, 0, 8'd0, 1'b0);
        add_row(ROW_SET_CEILING, CMD_TICK, 10'd255, 0, 8'd0, 1'b0);
        add_row(ROW_ITEM, CMD_BURST, 10'd300, 1, 8'd255, 1'b0);
        add_row(ROW_ITEM, CMD_BURST, 10'd512, 0, 8'd0, 1'b0);
        add_row(ROW_ITEM, CMD_TICK, 10'd0, 0, 8'd0, 1'b0);
        add_row(ROW_ITEM, CMD_TICK, 10'd0, 1, 8'd0, 1'b0);
        // Smallest ceiling with the longest lifetime.
        add_row(ROW_SET_CEILING, CMD_TICK, 10'd1, 0, 8'd0, 1'b0);
        add_row(ROW_SET_LIFETIME, CMD_TICK, 10'd255, 0, 8'd0, 1'b0);
        add_row(ROW_ITEM, CMD_BURST, 10'h3FF, 1, 8'd1, 1'b0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table.
        for (int k = 0; k < directed_rows.size(); k++)
        begin
            row = directed_rows[k];
            case (row.kind)
                ROW_ITEM:
                begin
                    offer_command(row.cmd, row.value, row.typed, row.want);
                end
                ROW_SET_LIFETIME:
                begin
                    drain_results();
                    write_register(ADDR_LIFETIME, row.value[CNT_W-1:0]);
                end
                default:
                begin
                    drain_results();
                    write_register(ADDR_CEILING, row.value[CNT_W-1:0]);
                end
            endcase
        end

        // Random phases, each under its own lifetime and ceiling. The table is not
        // cleared between phases, so old cohorts meet the new settings.
        for (int p = 0; p < N_PHASES; p++)
        begin
            drain_results();
            case (p)
                0:
                begin
                    life = 8'd255;
                    ceil = 8'd255;
                end
                1:
                begin
                    life = 8'd0;
                    ceil = 8'd255;
                end
                2:
                begin
                    life = 8'd1;
                    ceil = 8'd1;
                end
                3:
                begin
                    life = 8'd255;
                    ceil = 8'd1;
                end
                4:
                begin
                    life = 8'd3;
                    ceil = 8'd20;
                end
                5:
                begin
                    life = 8'd2;
                    ceil = 8'd200;
                end
                default:
                begin
                    life = (p % 2 == 1) ? cnt_t'($urandom_range(0, 12))
                                        : cnt_t'($urandom_range(0, 255));
                    ceil = cnt_t'($urandom_range(1, 255));
                end
            endcase
            write_register(ADDR_LIFETIME, life);
            write_register(ADDR_CEILING, ceil);
            quiet_phase = (p == 0 || p == 5);
            if (p == 3)
                hold_off_pending = 1'b1;

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    cmd = CMD_BURST;
                else if (r < 94)
                    cmd = CMD_TICK;
                else
                    cmd = CMD_CLEAR;
                // Burst sizes mostly around the ceiling, some over the whole field.
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    amount = BURST_W'($urandom_range(0, int'(cur_ceiling) * 3 / 2));
                end
                else if (r < 85)
                begin
                    amount = BURST_W'($urandom_range(0, 1023));
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       amount = '0;
                        1:       amount = '1;
                        2:       amount = BURST_W'(cur_ceiling);
                        default: amount = BURST_W'(cur_ceiling) + 10'd1;
                    endcase
                end
                offer_command(cmd, amount, 0, '0);
            end
        end

        drain_results();
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("Ran %0d commands under %0d lifetime/ceiling settings; %0d results checked.",
                 items_sent, N_PHASES + 4, results_seen);
        $display("%0d results reported folded bursts; one %0d-cycle result hold-off was applied.",
                 folds_seen, HOLD_OFF_CYCLES);
        if (error_count == 0 && expected_bounds.size() == 0)
        begin
            $display("tb_lifetime_cohort_bound_tracker: PASS");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived",
                     error_count, expected_bounds.size());
            $display("tb_lifetime_cohort_bound_tracker: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/lcbt_pkg.sv
hdl/lcbt_table.sv
hdl/lifetime_cohort_bound_tracker.sv
dv/tb_lifetime_cohort_bound_tracker.sv
